@@ hdl/mpta_pkg.sv @@
// ----------------------------------------------------------------------------
// mpta_pkg
// Shared types and constants of the MAC peer traffic accounting block.
// ----------------------------------------------------------------------------
package mpta_pkg;

   localparam int MAC_W    = 48;
   localparam int LEN_W    = 16;
   localparam int BYTES_W  = 32;
   localparam int PERIOD_W = 16;

   localparam logic [MAC_W-1:0]   BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
   localparam int                 MCAST_BIT   = 40;
   localparam logic [BYTES_W-1:0] ALARM_RESET = 32'd1048576;

   // input commands
   localparam logic CMD_ACCOUNT = 1'b0;
   localparam logic CMD_REPORT  = 1'b1;

   // result kinds
   localparam logic KIND_TOTALS = 1'b0;
   localparam logic KIND_PEER   = 1'b1;

   // configuration register indexes
   localparam int                CSR_INDEX_W = 1;
   localparam int                CSR_DATA_W  = 48;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_MAC         = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_THRESHOLD = 1'd1;

   typedef struct packed {
      logic               command;
      logic [MAC_W-1:0]   src_mac;
      logic [MAC_W-1:0]   dst_mac;
      logic [LEN_W-1:0]   frame_length;
   } req_payload_type;

   typedef struct packed {
      logic                kind;
      logic [PERIOD_W-1:0] period_index;
      logic [BYTES_W-1:0]  total_received;
      logic [BYTES_W-1:0]  total_multicast;
      logic [BYTES_W-1:0]  total_broadcast;
      logic [BYTES_W-1:0]  total_sent;
      logic [MAC_W-1:0]    peer_mac;
      logic [BYTES_W-1:0]  bytes_to_peer;
      logic [BYTES_W-1:0]  bytes_from_peer;
      logic                over_threshold;
      logic                last;
   } rsp_payload_type;

   // one peer table row
   typedef struct packed {
      logic [MAC_W-1:0]   peer_address;
      logic [BYTES_W-1:0] sent_bytes;
      logic [BYTES_W-1:0] received_bytes;
   } peer_row_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_LOAD       = 3'd1,
      OP_DECODE     = 3'd2,
      OP_SEARCH     = 3'd3,
      OP_REP_TOTALS = 3'd4,
      OP_REP_READ   = 3'd5,
      OP_REP_EMIT   = 3'd6
   } op_type;

   typedef struct packed {
      logic   take;
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_report;
      logic counted;
      logic count_zero;
      logic hit;
      logic miss_done;
      logic slot_free;
      logic last_entry;
   } ctrl_status_type;

   // saturating add of a frame length to a peer count
   function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                   input logic [LEN_W-1:0]   b);
      logic [BYTES_W:0] sum;
      begin
         sum = {1'b0, a} + {{(BYTES_W+1-LEN_W){1'b0}}, b};
         sat_add = sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
      end
   endfunction

endpackage

@@ hdl/mpta_if.sv @@
// ----------------------------------------------------------------------------
// mpta_req_if / mpta_rsp_if
// Valid/ready channels for frame requests and report results.
// ----------------------------------------------------------------------------
interface mpta_req_if;
   logic                     valid;
   logic                     ready;
   mpta_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mpta_rsp_if;
   logic                     valid;
   logic                     ready;
   mpta_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/mac_peer_traffic_accounting.sv @@
// ----------------------------------------------------------------------------
// mac_peer_traffic_accounting
// Per-peer MAC byte accounting with period totals and report runs.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            carries
//  req_chan  in         valid/ready          command, src/dst MAC, length
//  rsp_chan  out        valid/ready          totals result, then peer rows
//  csr_*     in         write enable only    own_mac, alarm_threshold
//
//  An account transaction loads in idle, classifies in decode and, for a
//  counted frame, searches the table with one read per cycle until a hit or
//  the last entry; a peer that misses is inserted when there is room. An
//  ignored frame returns from decode to idle. A report emits the totals, then
//  reads and emits each entry; every stall on rsp_chan holds the report.
//  Synchronous active-high reset clears counts, totals and the period number;
//  table rows need no clearing since only rows below the entry count are read.
//  req_chan is ready only in idle; a result waiting in the output register
//  does not block the next request.
// ----------------------------------------------------------------------------
module mac_peer_traffic_accounting #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   mpta_req_if.sink                         req_chan,
   mpta_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [mpta_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mpta_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   mpta_pkg::ctrl_cmd_type    ctrl_cmd;
   mpta_pkg::ctrl_status_type ctrl_status;

   // request handshake follows the controller
   assign req_chan.ready = ctrl_cmd.take;

   mpta_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .status   (ctrl_status),
      .cmd      (ctrl_cmd)
   );

   mpta_dp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_payload     (req_chan.payload),
      .cmd             (ctrl_cmd),
      .status          (ctrl_status),
      .rsp_chan        (rsp_chan)
   );

endmodule

@@ hdl/mpta_ram.sv @@
// ----------------------------------------------------------------------------
// mpta_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mpta_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mpta_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpta_ctrl
// Controller: sequences accept, classify, table search and report output.
// ----------------------------------------------------------------------------
module mpta_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  mpta_pkg::ctrl_status_type status,
   output mpta_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_DECODE     = 6'b000010,
      ST_SEARCH     = 6'b000100,
      ST_REP_TOTALS = 6'b001000,
      ST_REP_READ   = 6'b010000,
      ST_REP_EMIT   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.take = 1'b0;
      cmd.op   = mpta_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (req_valid) begin
               cmd.op   = mpta_pkg::OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.op = mpta_pkg::OP_DECODE;
            if (status.is_report) begin
               state_in = ST_REP_TOTALS;
            end else if (status.counted) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            cmd.op = mpta_pkg::OP_SEARCH;
            if (status.hit || status.miss_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_REP_TOTALS: begin
            cmd.op = mpta_pkg::OP_REP_TOTALS;
            if (status.slot_free) begin
               state_in = status.count_zero ? ST_IDLE : ST_REP_READ;
            end
         end
         ST_REP_READ: begin
            cmd.op   = mpta_pkg::OP_REP_READ;
            state_in = ST_REP_EMIT;
         end
         ST_REP_EMIT: begin
            cmd.op = mpta_pkg::OP_REP_EMIT;
            if (status.slot_free) begin
               state_in = status.last_entry ? ST_IDLE : ST_REP_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a report with an empty table goes straight back to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REP_TOTALS && status.slot_free && status.count_zero)
      |=> (state_ff == ST_IDLE))
      else $error("empty report did not return to idle");

endmodule

@@ hdl/mpta_dp.sv @@
// ----------------------------------------------------------------------------
// mpta_dp
// Datapath: config registers, classifier, totals, peer table search and
// insertion, and the result output register.
// ----------------------------------------------------------------------------
module mpta_dp #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [mpta_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mpta_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  mpta_pkg::req_payload_type              req_payload,
   input  mpta_pkg::ctrl_cmd_type                 cmd,
   output mpta_pkg::ctrl_status_type              status,
   mpta_rsp_if.source                             rsp_chan
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int RW = $bits(mpta_pkg::peer_row_type);

   logic [mpta_pkg::MAC_W-1:0]    own_mac_ff;
   logic [mpta_pkg::BYTES_W-1:0]  threshold_ff;
   mpta_pkg::req_payload_type     item_ff;
   logic [mpta_pkg::BYTES_W-1:0]  received_ff;
   logic [mpta_pkg::BYTES_W-1:0]  multicast_ff;
   logic [mpta_pkg::BYTES_W-1:0]  broadcast_ff;
   logic [mpta_pkg::BYTES_W-1:0]  sent_ff;
   logic [mpta_pkg::PERIOD_W-1:0] period_ff;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 scan_ff;
   logic                          pend_ff;
   logic [IW-1:0]                 pend_idx_ff;
   logic [CW-1:0]                 rep_idx_ff;
   logic                          rsp_valid_ff;
   mpta_pkg::rsp_payload_type     rsp_payload_ff;

   logic                          is_sent;
   logic                          is_unicast;
   logic                          is_broadcast;
   logic                          is_multicast;
   logic                          counted;
   logic [mpta_pkg::MAC_W-1:0]    peer;
   logic [mpta_pkg::BYTES_W-1:0]  len32;
   logic                          issue;
   logic                          hit;
   logic                          miss_done;
   logic                          slot_free;
   logic                          last_entry;
   logic                          table_full;
   logic                          clear_period;
   logic                          load_totals;
   logic                          load_entry;
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   mpta_pkg::peer_row_type        wr_row;
   logic [IW-1:0]                 rd_addr;
   logic [RW-1:0]                 rd_data;
   mpta_pkg::peer_row_type        rd_row;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff   <= '0;
         threshold_ff <= mpta_pkg::ALARM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mpta_pkg::CSR_OWN_MAC:         own_mac_ff   <= csr_write_data;
            mpta_pkg::CSR_ALARM_THRESHOLD: threshold_ff <= csr_write_data[mpta_pkg::BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // latched transaction
   always_ff @(posedge clock) begin
      if (cmd.op == mpta_pkg::OP_LOAD) begin
         item_ff <= req_payload;
      end
   end

   // frame classification, in priority order
   always_comb begin
      is_sent      = (item_ff.src_mac == own_mac_ff);
      is_unicast   = !is_sent && (item_ff.dst_mac == own_mac_ff);
      is_broadcast = !is_sent && !is_unicast && (item_ff.dst_mac == mpta_pkg::BCAST_MAC);
      is_multicast = !is_sent && !is_unicast && !is_broadcast
                     && item_ff.dst_mac[mpta_pkg::MCAST_BIT];
      counted      = is_sent || is_unicast || is_broadcast || is_multicast;
      peer         = is_sent ? item_ff.dst_mac : item_ff.src_mac;
      len32        = {{(mpta_pkg::BYTES_W-mpta_pkg::LEN_W){1'b0}}, item_ff.frame_length};
   end

   // search and report control terms
   assign rd_row     = mpta_pkg::peer_row_type'(rd_data);
   assign issue      = (scan_ff < count_ff);
   assign hit        = pend_ff && (rd_row.peer_address == peer);
   assign miss_done  = !pend_ff && !issue;
   assign table_full = (count_ff >= CW'(TABLE_DEPTH));
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_entry = ((rep_idx_ff + CW'(1)) == count_ff);
   assign load_totals = (cmd.op == mpta_pkg::OP_REP_TOTALS) && slot_free;
   assign load_entry  = (cmd.op == mpta_pkg::OP_REP_EMIT) && slot_free;
   assign clear_period = (load_totals && (count_ff == '0)) || (load_entry && last_entry);

   // table write: update on hit, insert on miss when there is room
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_idx_ff;
      wr_row  = rd_row;
      if (cmd.op == mpta_pkg::OP_SEARCH) begin
         if (hit) begin
            wr_en = 1'b1;
            if (is_sent) begin
               wr_row.sent_bytes = mpta_pkg::sat_add(rd_row.sent_bytes, item_ff.frame_length);
            end else begin
               wr_row.received_bytes =
                  mpta_pkg::sat_add(rd_row.received_bytes, item_ff.frame_length);
            end
         end else if (miss_done && !table_full) begin
            wr_en                 = 1'b1;
            wr_addr               = count_ff[IW-1:0];
            wr_row.peer_address   = peer;
            wr_row.sent_bytes     = is_sent ? len32 : '0;
            wr_row.received_bytes = is_sent ? '0 : len32;
         end
      end
   end

   assign rd_addr = (cmd.op == mpta_pkg::OP_SEARCH) ? scan_ff[IW-1:0] : rep_idx_ff[IW-1:0];

   // totals, entry count and period number
   always_ff @(posedge clock) begin
      if (reset) begin
         received_ff  <= '0;
         multicast_ff <= '0;
         broadcast_ff <= '0;
         sent_ff      <= '0;
         count_ff     <= '0;
         period_ff    <= '0;
      end else begin
         if ((cmd.op == mpta_pkg::OP_DECODE) && (item_ff.command == mpta_pkg::CMD_ACCOUNT)) begin
            if (is_sent) begin
               sent_ff <= sent_ff + len32;
            end
            if (is_unicast || is_broadcast || is_multicast) begin
               received_ff <= received_ff + len32;
            end
            if (is_broadcast) begin
               broadcast_ff <= broadcast_ff + len32;
            end
            if (is_multicast) begin
               multicast_ff <= multicast_ff + len32;
            end
         end
         if ((cmd.op == mpta_pkg::OP_SEARCH) && miss_done && !hit && !table_full) begin
            count_ff <= count_ff + CW'(1);
         end
         if (load_totals) begin
            period_ff <= period_ff + mpta_pkg::PERIOD_W'(1);
         end
         if (clear_period) begin
            received_ff  <= '0;
            multicast_ff <= '0;
            broadcast_ff <= '0;
            sent_ff      <= '0;
            count_ff     <= '0;
         end
      end
   end

   // search pointer and in-flight read tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         pend_ff     <= 1'b0;
         pend_idx_ff <= '0;
         rep_idx_ff  <= '0;
      end else begin
         case (cmd.op)
            mpta_pkg::OP_DECODE: begin
               scan_ff    <= '0;
               pend_ff    <= 1'b0;
               rep_idx_ff <= '0;
            end
            mpta_pkg::OP_SEARCH: begin
               pend_ff     <= issue;
               pend_idx_ff <= scan_ff[IW-1:0];
               if (issue) begin
                  scan_ff <= scan_ff + CW'(1);
               end
            end
            mpta_pkg::OP_REP_EMIT: begin
               if (slot_free && !last_entry) begin
                  rep_idx_ff <= rep_idx_ff + CW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_totals || load_entry) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_totals) begin
         rsp_payload_ff                 <= '0;
         rsp_payload_ff.kind            <= mpta_pkg::KIND_TOTALS;
         rsp_payload_ff.period_index    <= period_ff + mpta_pkg::PERIOD_W'(1);
         rsp_payload_ff.total_received  <= received_ff;
         rsp_payload_ff.total_multicast <= multicast_ff;
         rsp_payload_ff.total_broadcast <= broadcast_ff;
         rsp_payload_ff.total_sent      <= sent_ff;
         rsp_payload_ff.last            <= (count_ff == '0);
      end else if (load_entry) begin
         rsp_payload_ff                 <= '0;
         rsp_payload_ff.kind            <= mpta_pkg::KIND_PEER;
         rsp_payload_ff.period_index    <= period_ff;
         rsp_payload_ff.peer_mac        <= rd_row.peer_address;
         rsp_payload_ff.bytes_to_peer   <= rd_row.sent_bytes;
         rsp_payload_ff.bytes_from_peer <= rd_row.received_bytes;
         rsp_payload_ff.over_threshold  <= (rd_row.sent_bytes > threshold_ff)
                                           || (rd_row.received_bytes > threshold_ff);
         rsp_payload_ff.last            <= last_entry;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // peer table storage
   mpta_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_DEPTH),
      .ADDR_W(IW)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_row),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // status to the controller
   always_comb begin
      status.is_report  = (item_ff.command == mpta_pkg::CMD_REPORT);
      status.counted    = counted;
      status.count_zero = (count_ff == '0);
      status.hit        = hit;
      status.miss_done  = miss_done;
      status.slot_free  = slot_free;
      status.last_entry = last_entry;
   end

   // entry count never passes the table depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("peer entry count beyond table depth");

   // the table is written only while searching
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cmd.op == mpta_pkg::OP_SEARCH))
      else $error("table write outside search");

   // a loaded result is presented in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (load_totals || load_entry) |=> rsp_valid_ff)
      else $error("loaded result not presented");

   // a finished report leaves the table and totals empty
   assert property (@(posedge clock) disable iff (reset)
      clear_period |=> (count_ff == '0 && sent_ff == '0 && received_ff == '0))
      else $error("report did not clear the period state");

endmodule
